// ===== rtl/pidpc_pkg.sv =====
// ----------------------------------------------------------------------------
// pidpc_pkg
// Shared widths, defaults, register indexes and pipeline control type of the
// PID position controller.
// ----------------------------------------------------------------------------
package pidpc_pkg;

   localparam int SAMPLE_BITS_DEF    = 12;
   localparam int GAIN_FRAC_BITS_DEF = 8;

   localparam int GAIN_W    = 16;   // Q8.8 gains at the default GAIN_FRAC_BITS
   localparam int DRIVE_W   = 16;
   localparam int SUM_W     = 32;   // saturating integral
   localparam int CSR_IDX_W = 3;
   localparam int CSR_W     = 16;   // widest register

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GAIN_PROP    = 3'd0,
      CSR_GAIN_INTEG   = 3'd1,
      CSR_GAIN_DERIV   = 3'd2,
      CSR_TARGET_VALUE = 3'd3,
      CSR_UPPER_LIMIT  = 3'd4,
      CSR_LOWER_LIMIT  = 3'd5,
      CSR_RUN_ENABLE   = 3'd6
   } csr_index_type;

   // travels alongside the payload of each stage
   typedef struct packed {
      logic valid;
      logic run;     // loop was enabled when the word came in
   } pidpc_ctl_type;

endpackage

// ===== rtl/pidpc_err_stage.sv =====
// ----------------------------------------------------------------------------
// pidpc_err_stage
// Error, saturating integral and derivative difference; holds loop state.
// ----------------------------------------------------------------------------
module pidpc_err_stage #(
   parameter int SAMPLE_BITS = pidpc_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     in_valid,
   output logic                                     in_ready,
   input  logic [SAMPLE_BITS-1:0]                   meas,
   input  logic [SAMPLE_BITS-1:0]                   target,
   input  logic                                     run,
   input  logic                                     clear,
   input  logic                                     down_ready,
   output pidpc_pkg::pidpc_ctl_type                 ctl,
   output logic signed [SAMPLE_BITS:0]              err,
   output logic signed [pidpc_pkg::SUM_W-1:0]       sum,
   output logic signed [SAMPLE_BITS+1:0]            delta
);

   localparam int ERR_W   = SAMPLE_BITS + 1;
   localparam int DELTA_W = SAMPLE_BITS + 2;
   localparam int SUM_W   = pidpc_pkg::SUM_W;

   pidpc_pkg::pidpc_ctl_type   ctl_ff, ctl_in;
   logic signed [ERR_W-1:0]    err_ff, last_error_ff, last_error_in, err_w;
   logic signed [SUM_W-1:0]    sum_ff, error_sum_ff, error_sum_in, sum_sat;
   logic signed [DELTA_W-1:0]  delta_ff, delta_w;
   logic signed [SUM_W:0]      sum_wide;
   logic                       accept;

   assign in_ready = !ctl_ff.valid || down_ready;
   assign accept   = in_valid && in_ready;

   assign err_w    = $signed({1'b0, target}) - $signed({1'b0, meas});
   assign delta_w  = DELTA_W'(last_error_ff) - DELTA_W'(err_w);
   assign sum_wide = (SUM_W+1)'(error_sum_ff) + (SUM_W+1)'(err_w);

   // overflow shows as differing top two bits
   always_comb begin
      if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
         sum_sat = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                   : {1'b0, {(SUM_W-1){1'b1}}};
      end else begin
         sum_sat = sum_wide[SUM_W-1:0];
      end
   end

   always_comb begin
      ctl_in = ctl_ff;
      if (in_ready) begin
         ctl_in.valid = in_valid;
         ctl_in.run   = run;
      end
   end

   always_comb begin
      error_sum_in  = error_sum_ff;
      last_error_in = last_error_ff;
      if (clear) begin
         error_sum_in  = '0;
         last_error_in = '0;
      end else if (accept && run) begin
         error_sum_in  = sum_sat;
         last_error_in = err_w;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff        <= '0;
         error_sum_ff  <= '0;
         last_error_ff <= '0;
      end else begin
         ctl_ff        <= ctl_in;
         error_sum_ff  <= error_sum_in;
         last_error_ff <= last_error_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         err_ff   <= err_w;
         sum_ff   <= sum_sat;
         delta_ff <= delta_w;
      end
   end

   assign ctl   = ctl_ff;
   assign err   = err_ff;
   assign sum   = sum_ff;
   assign delta = delta_ff;

   a_clear_state: assert property (@(posedge clock) disable iff (reset)
      clear |=> (error_sum_ff == '0 && last_error_ff == '0))
      else $error("setpoint write did not clear loop state");

   a_idle_hold: assert property (@(posedge clock) disable iff (reset)
      (!clear && !(accept && run)) |=> ($stable(error_sum_ff) && $stable(last_error_ff)))
      else $error("loop state moved without an enabled word");

   a_no_wrap: assert property (@(posedge clock) disable iff (reset)
      (!clear && accept && run && !err_w[ERR_W-1])
      |=> (error_sum_ff >= $past(error_sum_ff)))
      else $error("integral wrapped on a non-negative error");

endmodule

// ===== rtl/pidpc_mult_stage.sv =====
// ----------------------------------------------------------------------------
// pidpc_mult_stage
// The three gain products, each registered.
// ----------------------------------------------------------------------------
module pidpc_mult_stage #(
   parameter int SAMPLE_BITS = pidpc_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                                  clock,
   input  logic                                                  reset,
   input  pidpc_pkg::pidpc_ctl_type                              up_ctl,
   output logic                                                  up_ready,
   input  logic signed [SAMPLE_BITS:0]                           err,
   input  logic signed [pidpc_pkg::SUM_W-1:0]                    sum,
   input  logic signed [SAMPLE_BITS+1:0]                         delta,
   input  logic signed [pidpc_pkg::GAIN_W-1:0]                   gain_prop,
   input  logic signed [pidpc_pkg::GAIN_W-1:0]                   gain_integ,
   input  logic signed [pidpc_pkg::GAIN_W-1:0]                   gain_deriv,
   input  logic                                                  down_ready,
   output pidpc_pkg::pidpc_ctl_type                              ctl,
   output logic signed [pidpc_pkg::GAIN_W+SAMPLE_BITS:0]         prod_p,
   output logic signed [pidpc_pkg::GAIN_W+pidpc_pkg::SUM_W-1:0]  prod_i,
   output logic signed [pidpc_pkg::GAIN_W+SAMPLE_BITS+1:0]       prod_d
);

   localparam int P_W = pidpc_pkg::GAIN_W + SAMPLE_BITS + 1;
   localparam int I_W = pidpc_pkg::GAIN_W + pidpc_pkg::SUM_W;
   localparam int D_W = pidpc_pkg::GAIN_W + SAMPLE_BITS + 2;

   pidpc_pkg::pidpc_ctl_type ctl_ff, ctl_in;
   logic signed [P_W-1:0]    prod_p_ff;
   logic signed [I_W-1:0]    prod_i_ff;
   logic signed [D_W-1:0]    prod_d_ff;
   logic                     load;

   assign up_ready = !ctl_ff.valid || down_ready;
   assign load     = up_ctl.valid && up_ready;

   always_comb begin
      ctl_in = ctl_ff;
      if (up_ready) begin
         ctl_in = up_ctl;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         prod_p_ff <= P_W'(gain_prop) * P_W'(err);
         prod_i_ff <= I_W'(gain_integ) * I_W'(sum);
         prod_d_ff <= D_W'(gain_deriv) * D_W'(delta);
      end
   end

   assign ctl    = ctl_ff;
   assign prod_p = prod_p_ff;
   assign prod_i = prod_i_ff;
   assign prod_d = prod_d_ff;

endmodule

// ===== rtl/pidpc_out_stage.sv =====
// ----------------------------------------------------------------------------
// pidpc_out_stage
// Product sum, then scaling toward zero, saturation, clamp and result register.
// ----------------------------------------------------------------------------
module pidpc_out_stage #(
   parameter int SAMPLE_BITS    = pidpc_pkg::SAMPLE_BITS_DEF,
   parameter int GAIN_FRAC_BITS = pidpc_pkg::GAIN_FRAC_BITS_DEF
) (
   input  logic                                                  clock,
   input  logic                                                  reset,
   input  pidpc_pkg::pidpc_ctl_type                              up_ctl,
   output logic                                                  up_ready,
   input  logic signed [pidpc_pkg::GAIN_W+SAMPLE_BITS:0]         prod_p,
   input  logic signed [pidpc_pkg::GAIN_W+pidpc_pkg::SUM_W-1:0]  prod_i,
   input  logic signed [pidpc_pkg::GAIN_W+SAMPLE_BITS+1:0]       prod_d,
   input  logic signed [pidpc_pkg::DRIVE_W-1:0]                  upper_limit,
   input  logic signed [pidpc_pkg::DRIVE_W-1:0]                  lower_limit,
   output logic                                                  out_valid,
   input  logic                                                  out_ready,
   output logic signed [pidpc_pkg::DRIVE_W-1:0]                  drive
);

   localparam int DRIVE_W = pidpc_pkg::DRIVE_W;
   // integral product is the widest term for every sample width in range
   localparam int ACC_W   = pidpc_pkg::GAIN_W + pidpc_pkg::SUM_W + 2;
   localparam logic [ACC_W-1:0] FRAC_MASK =
      ACC_W'((64'd1 << GAIN_FRAC_BITS) - 64'd1);
   localparam logic signed [ACC_W-1:0] DRIVE_MAX = ACC_W'(32767);
   localparam logic signed [ACC_W-1:0] DRIVE_MIN = ACC_W'(-32768);

   pidpc_pkg::pidpc_ctl_type     acc_ctl_ff, acc_ctl_in;
   logic signed [ACC_W-1:0]      acc_ff, acc_w, acc_adj, acc_scaled;
   logic signed [DRIVE_W-1:0]    sat_w, clamp_w, drive_ff, drive_in;
   logic                         out_valid_ff, out_valid_in, res_ready, acc_load;

   // stage 1: product sum
   assign res_ready = !out_valid_ff || out_ready;
   assign up_ready  = !acc_ctl_ff.valid || res_ready;
   assign acc_load  = up_ctl.valid && up_ready;
   assign acc_w     = ACC_W'(prod_p) + ACC_W'(prod_i) + ACC_W'(prod_d);

   always_comb begin
      acc_ctl_in = acc_ctl_ff;
      if (up_ready) begin
         acc_ctl_in = up_ctl;
      end
   end

   // stage 2: scale toward zero, saturate, clamp
   assign acc_adj    = acc_ff + (acc_ff[ACC_W-1] ? $signed(FRAC_MASK) : $signed(ACC_W'(0)));
   assign acc_scaled = acc_adj >>> GAIN_FRAC_BITS;

   always_comb begin
      if (acc_scaled > DRIVE_MAX) begin
         sat_w = DRIVE_W'(DRIVE_MAX);
      end else if (acc_scaled < DRIVE_MIN) begin
         sat_w = DRIVE_W'(DRIVE_MIN);
      end else begin
         sat_w = acc_scaled[DRIVE_W-1:0];
      end
   end

   // upper first, lower wins when the limits are crossed
   always_comb begin
      clamp_w = sat_w;
      if (upper_limit != '0 && lower_limit != '0) begin
         if (clamp_w > upper_limit) begin
            clamp_w = upper_limit;
         end
         if (clamp_w < lower_limit) begin
            clamp_w = lower_limit;
         end
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      drive_in     = drive_ff;
      if (res_ready) begin
         out_valid_in = acc_ctl_ff.valid;
         drive_in     = acc_ctl_ff.run ? clamp_w : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ctl_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         acc_ctl_ff   <= acc_ctl_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (acc_load) begin
         acc_ff <= acc_w;
      end
      drive_ff <= drive_in;
   end

   assign out_valid = out_valid_ff;
   assign drive     = drive_ff;

endmodule

// ===== rtl/pid_position_controller_unit.sv =====
// ----------------------------------------------------------------------------
// pid_position_controller_unit
// Fixed-point PID loop with saturating integral and optional output clamp.
// ----------------------------------------------------------------------------
// Pipeline: a word passes the error, product, sum and result registers (4 register stages).
// Throughput: one word per cycle unless rsp_ stalls; a stage holds while the next is full.
// The loop state (integral, last error) is updated in the first stage, so
// back-to-back samples see each other's state with no gap.
// Reset (synchronous, active high): state, config and valid flags to 0; data regs not reset.
// ----------------------------------------------------------------------------
module pid_position_controller_unit #(
   parameter int SAMPLE_BITS    = pidpc_pkg::SAMPLE_BITS_DEF,     // 8..16
   parameter int GAIN_FRAC_BITS = pidpc_pkg::GAIN_FRAC_BITS_DEF   // 0..12
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // sample channel
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [((SAMPLE_BITS+7)/8)*8-1:0]      req_tdata,   // [SAMPLE_BITS-1:0] measurement
   // drive channel
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [pidpc_pkg::DRIVE_W-1:0]         rsp_tdata,   // [15:0] drive
   // register writes
   input  logic                                  csr_we,
   input  logic [pidpc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [pidpc_pkg::CSR_W-1:0]           csr_wdata
);

   localparam int GAIN_W  = pidpc_pkg::GAIN_W;
   localparam int SUM_W   = pidpc_pkg::SUM_W;
   localparam int DRIVE_W = pidpc_pkg::DRIVE_W;

   // ---- configuration registers ----
   logic signed [GAIN_W-1:0]   gain_prop_ff, gain_integ_ff, gain_deriv_ff;
   logic signed [DRIVE_W-1:0]  upper_limit_ff, lower_limit_ff;
   logic [SAMPLE_BITS-1:0]     target_value_ff;
   logic                       run_enable_ff;
   logic                       target_clear;

   // a setpoint write also clears the loop state in the error stage
   assign target_clear = csr_we &&
      (pidpc_pkg::csr_index_type'(csr_index) == pidpc_pkg::CSR_TARGET_VALUE);

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_prop_ff    <= '0;
         gain_integ_ff   <= '0;
         gain_deriv_ff   <= '0;
         target_value_ff <= '0;
         upper_limit_ff  <= '0;
         lower_limit_ff  <= '0;
         run_enable_ff   <= 1'b0;
      end else if (csr_we) begin
         case (pidpc_pkg::csr_index_type'(csr_index))
            pidpc_pkg::CSR_GAIN_PROP:    gain_prop_ff    <= csr_wdata[GAIN_W-1:0];
            pidpc_pkg::CSR_GAIN_INTEG:   gain_integ_ff   <= csr_wdata[GAIN_W-1:0];
            pidpc_pkg::CSR_GAIN_DERIV:   gain_deriv_ff   <= csr_wdata[GAIN_W-1:0];
            pidpc_pkg::CSR_TARGET_VALUE: target_value_ff <= csr_wdata[SAMPLE_BITS-1:0];
            pidpc_pkg::CSR_UPPER_LIMIT:  upper_limit_ff  <= csr_wdata[DRIVE_W-1:0];
            pidpc_pkg::CSR_LOWER_LIMIT:  lower_limit_ff  <= csr_wdata[DRIVE_W-1:0];
            pidpc_pkg::CSR_RUN_ENABLE:   run_enable_ff   <= csr_wdata[0];
            default: ;   // unknown index: write dropped
         endcase
      end
   end

   // ---- stage 1: error, integral, derivative difference ----
   pidpc_pkg::pidpc_ctl_type      err_ctl, mul_ctl;
   logic signed [SAMPLE_BITS:0]   err;
   logic signed [SUM_W-1:0]       sum;
   logic signed [SAMPLE_BITS+1:0] delta;
   logic                          mul_up_ready, out_up_ready;

   pidpc_err_stage #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_err (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .meas       (req_tdata[SAMPLE_BITS-1:0]),
      .target     (target_value_ff),
      .run        (run_enable_ff),
      .clear      (target_clear),
      .down_ready (mul_up_ready),
      .ctl        (err_ctl),
      .err        (err),
      .sum        (sum),
      .delta      (delta)
   );

   // ---- stage 2: gain products ----
   logic signed [GAIN_W+SAMPLE_BITS:0]   prod_p;
   logic signed [GAIN_W+SUM_W-1:0]       prod_i;
   logic signed [GAIN_W+SAMPLE_BITS+1:0] prod_d;

   pidpc_mult_stage #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_mult (
      .clock      (clock),
      .reset      (reset),
      .up_ctl     (err_ctl),
      .up_ready   (mul_up_ready),
      .err        (err),
      .sum        (sum),
      .delta      (delta),
      .gain_prop  (gain_prop_ff),
      .gain_integ (gain_integ_ff),
      .gain_deriv (gain_deriv_ff),
      .down_ready (out_up_ready),
      .ctl        (mul_ctl),
      .prod_p     (prod_p),
      .prod_i     (prod_i),
      .prod_d     (prod_d)
   );

   // ---- stages 3 and 4: sum, scale, saturate, clamp, result register ----
   logic signed [DRIVE_W-1:0] drive;

   pidpc_out_stage #(
      .SAMPLE_BITS    (SAMPLE_BITS),
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
   ) u_out (
      .clock       (clock),
      .reset       (reset),
      .up_ctl      (mul_ctl),
      .up_ready    (out_up_ready),
      .prod_p      (prod_p),
      .prod_i      (prod_i),
      .prod_d      (prod_d),
      .upper_limit (upper_limit_ff),
      .lower_limit (lower_limit_ff),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .drive       (drive)
   );

   assign rsp_tdata = drive;

   // an empty first stage must always take a word
   a_first_free: assert property (@(posedge clock) disable iff (reset)
      !err_ctl.valid |-> req_tready)
      else $error("sample channel stalled with empty first stage");

endmodule
